### rtl/core/lsmt_pkg.sv
// Package: timing constants, mode codes and register indexes for the scanline mode timer.
`timescale 1ns / 1ps
`default_nettype none

package lsmt_pkg;

   localparam int OAM_DOTS      = 80;
   localparam int TRANSFER_DOTS = 172;
   localparam int HBLANK_DOTS   = 204;
   localparam int VISIBLE_LINES = 144;
   localparam int TOTAL_LINES   = 154;
   localparam int LINE_DOTS     = OAM_DOTS + TRANSFER_DOTS + HBLANK_DOTS;

   localparam int DOTS_W  = 5;
   localparam int DOT_W   = $clog2(LINE_DOTS + 32);
   localparam int LINE_W  = 8;
   localparam int SEL_W   = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam int SEL_MODE0_BIT = 0;
   localparam int SEL_LYC_BIT   = 3;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STAT_INT_SELECT = 1'd0,
      CSR_LINE_COMPARE    = 1'd1
   } csr_index_type;

endpackage

`default_nettype wire

### rtl/core/lsmt_if.sv
// Interfaces: request and response channels of the scanline mode timer.
`timescale 1ns / 1ps
`default_nettype none

interface lsmt_req_if import lsmt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DOTS_W-1:0] dots_elapsed;

   modport source (output valid, output dots_elapsed, input ready);
   modport sink   (input valid, input dots_elapsed, output ready);
endinterface

interface lsmt_rsp_if import lsmt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [LINE_W-1:0] line;
   logic              coincidence;
   logic              vblank_request;
   logic              status_request;
   logic              frame_done;

   modport source (output valid, output mode, output line, output coincidence,
                   output vblank_request, output status_request, output frame_done,
                   input ready);
   modport sink   (input valid, input mode, input line, input coincidence,
                   input vblank_request, input status_request, input frame_done,
                   output ready);
endinterface

`default_nettype wire

### rtl/core/lcd_scanline_mode_timer.sv
// Top level: display scanline mode timer with request/response channels and register port.
// Each request adds its elapsed dots to the dot counter and produces one response describing
// mode, line and events after the step. One request is taken every cycle; the response
// appears in the output register the cycle after acceptance, and a new request is taken
// while a response waits as long as the response slot is being drained in the same cycle.
// The step is a single dot-counter add with one compare and subtract against the current
// mode's length. Write the registers only while no response is pending.
`timescale 1ns / 1ps
`default_nettype none

module lcd_scanline_mode_timer import lsmt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lsmt_req_if.sink                   req,
   lsmt_rsp_if.source                 rsp,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SEL_W-1:0]  stat_sel_ff;
   logic [LINE_W-1:0] line_cmp_ff;

   mode_type          mode_ff, mode_in;
   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_mode_ff;
   logic [LINE_W-1:0] rsp_line_ff;
   logic              rsp_coin_ff, rsp_vblank_ff, rsp_status_ff, rsp_frame_ff;

   logic [DOT_W-1:0]  dot_sum;
   logic [LINE_W-1:0] line_inc;
   logic              vblank_in, status_in, frame_in;
   logic              accept;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      dot_sum   = dot_ff + DOT_W'(req.dots_elapsed);
      line_inc  = line_ff + LINE_W'(1);
      mode_in   = mode_ff;
      dot_in    = dot_sum;
      line_in   = line_ff;
      vblank_in = 1'b0;
      status_in = 1'b0;
      frame_in  = 1'b0;
      unique case (mode_ff)
         MODE_HBLANK: begin
            if (dot_sum >= DOT_W'(HBLANK_DOTS)) begin
               dot_in  = dot_sum - DOT_W'(HBLANK_DOTS);
               line_in = line_inc;
               if (line_inc == LINE_W'(VISIBLE_LINES)) begin
                  mode_in   = MODE_VBLANK;
                  vblank_in = 1'b1;
               end else begin
                  mode_in = MODE_OAM;
               end
            end
         end
         MODE_VBLANK: begin
            if (dot_sum >= DOT_W'(LINE_DOTS)) begin
               dot_in = dot_sum - DOT_W'(LINE_DOTS);
               if (line_inc >= LINE_W'(TOTAL_LINES)) begin
                  line_in  = '0;
                  frame_in = 1'b1;
                  mode_in  = MODE_OAM;
               end else begin
                  line_in = line_inc;
               end
            end
         end
         MODE_OAM: begin
            if (dot_sum >= DOT_W'(OAM_DOTS)) begin
               dot_in  = dot_sum - DOT_W'(OAM_DOTS);
               mode_in = MODE_XFER;
            end
         end
         MODE_XFER: begin
            if (dot_sum >= DOT_W'(TRANSFER_DOTS)) begin
               dot_in    = dot_sum - DOT_W'(TRANSFER_DOTS);
               mode_in   = MODE_HBLANK;
               status_in = stat_sel_ff[SEL_MODE0_BIT]
                        || (stat_sel_ff[SEL_LYC_BIT] && (line_ff == line_cmp_ff));
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_sel_ff  <= '0;
         line_cmp_ff  <= '0;
         mode_ff      <= MODE_OAM;
         dot_ff       <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_STAT_INT_SELECT: stat_sel_ff <= csr_wdata[SEL_W-1:0];
               CSR_LINE_COMPARE:    line_cmp_ff <= csr_wdata[LINE_W-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            mode_ff <= mode_in;
            dot_ff  <= dot_in;
            line_ff <= line_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff   <= mode_in;
         rsp_line_ff   <= line_in;
         rsp_coin_ff   <= (line_in == line_cmp_ff);
         rsp_vblank_ff <= vblank_in;
         rsp_status_ff <= status_in;
         rsp_frame_ff  <= frame_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.mode           = rsp_mode_ff;
   assign rsp.line           = rsp_line_ff;
   assign rsp.coincidence    = rsp_coin_ff;
   assign rsp.vblank_request = rsp_vblank_ff;
   assign rsp.status_request = rsp_status_ff;
   assign rsp.frame_done     = rsp_frame_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vblank_ff) |-> (rsp_mode_ff == MODE_VBLANK))
      else $error("vblank request outside vblank mode");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_ff) |-> (rsp_line_ff == '0 && rsp_mode_ff == MODE_OAM))
      else $error("frame done without wrap to line zero");

   a_status_hblank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_mode_ff == MODE_HBLANK))
      else $error("status request outside hblank entry");

   a_dot_bound: assert property (@(posedge clock) disable iff (reset)
      dot_ff < DOT_W'(LINE_DOTS + 32))
      else $error("dot counter out of range");

endmodule

`default_nettype wire

### test/tb.sv
// Testbench: checks the scanline mode timer response by response against a behavioral predictor.
`timescale 1ns / 1ps

module tb;
   import lsmt_pkg::*;

   typedef struct packed {
      mode_type          mode;
      logic [LINE_W-1:0] line;
      logic              coincidence;
      logic              vblank_request;
      logic              status_request;
      logic              frame_done;
   } scanline_status_type;

   class scanline_scoreboard;
      mode_type            phase;
      int unsigned         dot_total;
      logic [LINE_W-1:0]   line_num;
      logic [SEL_W-1:0]    int_select;
      logic [LINE_W-1:0]   compare_line;
      scanline_status_type expected_status_q[$];
      int                  errors;

      function void reset_state();
         phase            = MODE_OAM;
         dot_total        = 0;
         line_num         = '0;
         int_select       = '0;
         compare_line     = '0;
         errors           = 0;
         expected_status_q.delete();
      endfunction

      function void set_registers(logic [SEL_W-1:0] sel, logic [LINE_W-1:0] cmp);
         int_select   = sel;
         compare_line = cmp;
      endfunction

      function int pending();
         return expected_status_q.size();
      endfunction

      function void note_request(logic [DOTS_W-1:0] dots);
         scanline_status_type r;
         r = '0;
         dot_total += dots;
         case (phase)
            MODE_HBLANK: begin
               if (dot_total >= HBLANK_DOTS) begin
                  dot_total -= HBLANK_DOTS;
                  line_num  = line_num + 1'b1;
                  if (line_num == VISIBLE_LINES) begin
                     phase            = MODE_VBLANK;
                     r.vblank_request = 1'b1;
                  end else begin
                     phase = MODE_OAM;
                  end
               end
            end
            MODE_VBLANK: begin
               if (dot_total >= LINE_DOTS) begin
                  dot_total -= LINE_DOTS;
                  line_num  = line_num + 1'b1;
                  if (line_num >= TOTAL_LINES) begin
                     line_num     = '0;
                     r.frame_done = 1'b1;
                     phase        = MODE_OAM;
                  end
               end
            end
            MODE_OAM: begin
               if (dot_total >= OAM_DOTS) begin
                  dot_total -= OAM_DOTS;
                  phase     = MODE_XFER;
               end
            end
            default: begin
               if (dot_total >= TRANSFER_DOTS) begin
                  dot_total -= TRANSFER_DOTS;
                  phase     = MODE_HBLANK;
                  if (int_select[SEL_MODE0_BIT] ||
                      (int_select[SEL_LYC_BIT] && line_num == compare_line))
                     r.status_request = 1'b1;
               end
            end
         endcase
         r.mode        = phase;
         r.line        = line_num;
         r.coincidence = (line_num == compare_line);
         expected_status_q.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got_v);
         if (want != got_v) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got_v);
            errors++;
         end
      endfunction

      function void check_response(scanline_status_type got);
         scanline_status_type want;
         if (expected_status_q.size() == 0) begin
            $display("%0t unexpected response: expected none, actual mode %0d line %0d",
                     $time, got.mode, got.line);
            errors++;
            return;
         end
         want = expected_status_q.pop_front();
         compare_field("mode", want.mode, got.mode);
         compare_field("line", want.line, got.line);
         compare_field("coincidence", want.coincidence, got.coincidence);
         compare_field("vblank_request", want.vblank_request, got.vblank_request);
         compare_field("status_request", want.status_request, got.status_request);
         compare_field("frame_done", want.frame_done, got.frame_done);
      endfunction
   endclass

   localparam logic [DOTS_W-1:0] DIRECTED_DOTS [21] = '{
      5'd0, 5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd1, 5'd2,
      5'd4, 5'd8, 5'd16, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd0, 5'd15
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int send_idle_pct;
   int stall_pct;
   int hold_off_left;

   scanline_scoreboard sb;

   lsmt_req_if req_ch ();
   lsmt_rsp_if rsp_ch ();

   lcd_scanline_mode_timer u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("FAIL lcd_scanline_mode_timer");
      $finish;
   end

   // hold the receiver off while a long stall is pending, else stall at random
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : monitor
      scanline_status_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.mode           = mode_type'(rsp_ch.mode);
            got.line           = rsp_ch.line;
            got.coincidence    = rsp_ch.coincidence;
            got.vblank_request = rsp_ch.vblank_request;
            got.status_request = rsp_ch.status_request;
            got.frame_done     = rsp_ch.frame_done;
            sb.check_response(got);
         end
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.dots_elapsed);
      end
   end

   function automatic logic [DOTS_W-1:0] pick_dots(bit fast);
      if (fast)
         return ($urandom_range(99) < 80) ? DOTS_W'($urandom_range(20, 31))
                                          : DOTS_W'($urandom_range(0, 31));
      return ($urandom_range(99) < 85) ? DOTS_W'($urandom_range(0, 24))
                                       : DOTS_W'($urandom_range(25, 31));
   endfunction

   task automatic send_request(input logic [DOTS_W-1:0] dots);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid        <= 1'b0;
         req_ch.dots_elapsed <= DOTS_W'($urandom);
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.dots_elapsed <= dots;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic [SEL_W-1:0] sel, input logic [LINE_W-1:0] cmp);
      csr_write <= 1'b1;
      csr_index <= CSR_STAT_INT_SELECT;
      csr_wdata <= CSR_DATA_W'({4'($urandom_range(15)), sel});
      @(negedge clock);
      csr_index <= CSR_LINE_COMPARE;
      csr_wdata <= cmp;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_registers(sel, cmp);
      @(negedge clock);
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      send_idle_pct       = 0;
      stall_pct           = 0;
      hold_off_left       = 0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.dots_elapsed = '0;
      csr_write           = 1'b0;
      csr_index           = CSR_STAT_INT_SELECT;
      csr_wdata           = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_DOTS[i]) send_request(DIRECTED_DOTS[i]);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;  stall_pct = 0;
               configure(4'h1, 8'd0);
            end
            1: begin
               send_idle_pct = 74; stall_pct = 0;
               configure(4'h8, LINE_W'($urandom_range(0, TOTAL_LINES - 1)));
            end
            2: begin
               send_idle_pct = 0;  stall_pct = 74;
               configure(4'h6, 8'd255);
            end
            3: begin
               send_idle_pct = 15; stall_pct = 15;
               configure(4'hF, 8'(TOTAL_LINES - 1));
            end
            default: begin
               send_idle_pct = 0;  stall_pct = 0;
               configure(4'h9, LINE_W'($urandom_range(0, TOTAL_LINES - 1)));
               @(posedge clock);
               hold_off_left = 150;
               @(negedge clock);
            end
         endcase
         for (int n = 0; n < 120; n++) begin
            send_request(pick_dots(p == 0));
            if (p == 3 && n == 60) wait_drained();
         end
         wait_drained();
      end

      configure(4'h0, 8'd0);
      for (int n = 0; n < 20; n++) send_request(pick_dots(1'b0));
      wait_drained();

      if (sb.pending() != 0) begin
         $display("%0t leftover: expected %0d more responses, actual 0", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("PASS lcd_scanline_mode_timer");
      else
         $display("FAIL lcd_scanline_mode_timer");
      $finish;
   end

endmodule

### filelist.f
rtl/core/lsmt_pkg.sv
rtl/core/lsmt_if.sv
rtl/core/lcd_scanline_mode_timer.sv
test/tb.sv
